// File: design/apu_pkg.sv
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types, widths and constants of the Adam parameter update block.
// ----------------------------------------------------------------------------
package apu_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_PASS = 2'd2;

  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_BETA_ONE      = 2'd1;
  localparam logic [1:0] REG_BETA_TWO      = 2'd2;
  localparam logic [1:0] REG_STABILIZER    = 2'd3;

  localparam logic [23:0] LR_RESET   = 24'd838861;
  localparam logic [23:0] B1_RESET   = 24'd15099494;
  localparam logic [23:0] B2_RESET   = 24'd16760439;
  localparam logic [15:0] STAB_RESET = 16'd43;

  localparam int BP_W = 25;
  localparam logic [BP_W-1:0] ONE_Q24 = 25'd16777216;

  localparam int MUL_A_W   = 57;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 6;

  localparam int DIV_N_W   = 80;
  localparam int DIV_D_W   = 57;
  localparam int DIV_CNT_W = 7;

  localparam int SQ_X_W  = 64;
  localparam int ROOT_W  = 50;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int DELTA_W = 41;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         slot;
    logic signed [31:0] gradient;
    logic signed [15:0] start_value;
    logic               hold_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         slot_out;
    logic signed [15:0] rounded_value;
    logic signed [31:0] exact_value;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] first_moment;
    logic [31:0]        second_moment;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// File: design/apu_if.sv
// ----------------------------------------------------------------------------
// apu_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
interface apu_in_if;
  logic              valid;
  logic              ready;
  apu_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apu_out_if;
  logic               valid;
  logic               ready;
  apu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/adam_parameter_update.sv
// ----------------------------------------------------------------------------
// adam_parameter_update
// Adam optimizer over a table of parameter slots with serial arithmetic.
// ----------------------------------------------------------------------------
// The input channel takes one transaction at a time: a load writes a slot's
// start value and clears its moments, a step applies one gradient, and a new
// pass advances the running beta powers. Every transaction returns exactly
// one result transaction with the addressed slot's value, rounded and exact.
// Configuration writes go through the plain write port; the user must write
// only while the block idles, the block itself does not enforce it. A step
// uses the shared bit-serial multiplier, the restoring divider and the square
// root unit (normalizing, then 32 root bits). A step with the hold flag, or
// before the first pass, ends after the moment update.
// Reset returns the beta powers and registers to their defaults; the slot
// table is not cleared and a slot must be loaded before it is stepped.
// A result waits in the output register while the receiver stalls; the next
// transaction is accepted meanwhile and holds its result until the register
// frees up.
// ----------------------------------------------------------------------------
module adam_parameter_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  apu_in_if.sink      in_i,
  apu_out_if.source   out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL_M,
    S_MUL_G2,
    S_MUL_V,
    S_DIV_M,
    S_DIV_V,
    S_SQRT,
    S_MUL_L,
    S_DIV_L,
    S_PASS1,
    S_PASS2,
    S_WRITE,
    S_DONE
  } state_e;

  state_e state_q;

  logic [23:0] lr_q;
  logic [23:0] b1_q;
  logic [23:0] b2_q;
  logic [15:0] stab_q;

  logic [apu_pkg::BP_W-1:0] bp1_q;
  logic [apu_pkg::BP_W-1:0] bp2_q;

  logic [1:0]          act_q;
  logic [9:0]          slot_q;
  logic signed [31:0]  g_q;
  logic signed [15:0]  sv_q;
  logic                hold_q;
  logic signed [31:0]  val_q;
  logic signed [31:0]  m_q;
  logic [31:0]         v_q;
  logic [31:0]         g2_q;
  logic [55:0]         mh_q;
  logic [apu_pkg::DEN_W-1:0] den_q;

  logic               out_valid_q;
  apu_pkg::out_item_t out_q;

  logic mul_start_q;
  logic div_start_q;
  logic sq_start_q;

  // Memory.
  logic                       ram_we;
  logic [apu_pkg::ADDR_W-1:0] ram_addr;
  apu_pkg::row_t              ram_wdata;
  apu_pkg::row_t              ram_rdata;

  // Arithmetic units.
  logic [apu_pkg::MUL_CNT_W-1:0]       mul_cnt;
  logic signed [apu_pkg::MUL_A_W-1:0]  mul_a;
  logic [apu_pkg::MUL_B_W-1:0]         mul_b;
  logic                                mul_done;
  logic signed [apu_pkg::MUL_P_W-1:0]  mul_p;
  logic [apu_pkg::DIV_CNT_W-1:0]       div_cnt;
  logic [apu_pkg::DIV_N_W-1:0]         div_num;
  logic [apu_pkg::DIV_D_W-1:0]         div_den;
  logic                                div_done;
  logic [apu_pkg::DIV_N_W-1:0]         div_q;
  logic                                sq_done;
  logic [apu_pkg::ROOT_W-1:0]          sq_root;

  // Datapath terms.
  logic                      in_fire;
  logic                      slot_ok;
  logic                      out_free;
  logic [apu_pkg::BP_W-1:0]  d1;
  logic [apu_pkg::BP_W-1:0]  d2;
  logic signed [32:0]        dmg;
  logic signed [32:0]        dvg;
  logic [32:0]               ag33;
  logic [32:0]               am33;
  logic signed [59:0]        mx;
  logic signed [35:0]        m_sh;
  logic signed [31:0]        m_new;
  logic [64:0]               g2_sum;
  logic [59:0]               vx;
  logic [31:0]               v_new;
  logic [49:0]               bp_sum;
  logic [apu_pkg::DELTA_W-1:0] delta;
  logic signed [42:0]        dlt_s;
  logic signed [42:0]        nv;
  logic signed [31:0]        nv_sat;
  logic [apu_pkg::DEN_W-1:0] den_new;
  logic [32:0]               absv;
  logic [33:0]               rnd_sum;
  logic [16:0]               rnd_mag;
  logic signed [15:0]        rounded;

  assign in_fire  = in_i.valid && in_i.ready;
  assign slot_ok  = 32'(in_i.data.slot) < 32'(apu_pkg::SLOT_COUNT);
  assign out_free = !out_valid_q || out_o.ready;

  assign d1 = apu_pkg::ONE_Q24 - bp1_q;
  assign d2 = apu_pkg::ONE_Q24 - bp2_q;

  assign dmg  = 33'(m_q) - 33'(g_q);
  assign dvg  = $signed({1'b0, v_q}) - $signed({1'b0, g2_q});
  assign ag33 = g_q[31] ? -{g_q[31], g_q} : {1'b0, g_q};
  assign am33 = m_q[31] ? -{m_q[31], m_q} : {1'b0, m_q};

  // First moment: (g * 2^24 + b1 * (m - g) + 2^23) >> 24, saturated.
  assign mx    = (60'(g_q) <<< 24) + 60'(mul_p) + 60'sd8388608;
  assign m_sh  = mx[59:24];
  assign m_new = (m_sh > 36'sd2147483647) ? 32'sh7fffffff :
                 (m_sh < -36'sd2147483648) ? 32'sh80000000 : m_sh[31:0];

  assign g2_sum = 65'(mul_p[63:0]) + 65'd2147483648;

  // Second moment: (g2 * 2^24 + b2 * (v - g2) + 2^23) >> 24, saturated.
  assign vx    = (60'(g2_q) << 24) + 60'(mul_p) + 60'd8388608;
  assign v_new = (vx[59:56] != 4'd0) ? 32'hffffffff : vx[55:24];

  assign bp_sum = mul_p[49:0] + 50'd8388608;

  assign den_new = apu_pkg::DEN_W'(sq_root) + apu_pkg::DEN_W'(stab_q);

  assign delta = (div_q > 80'd1099511627776) ? 41'd1099511627776
                                              : div_q[apu_pkg::DELTA_W-1:0];
  assign dlt_s  = 43'(delta);
  assign nv     = 43'(val_q) + (m_q[31] ? dlt_s : -dlt_s);
  assign nv_sat = (nv > 43'sd2147483647) ? 32'sh7fffffff :
                  (nv < -43'sd2147483648) ? 32'sh80000000 : nv[31:0];

  // Round half away from zero to an integer, saturated to 16 bits.
  assign absv    = val_q[31] ? -{val_q[31], val_q} : {1'b0, val_q};
  assign rnd_sum = 34'(absv) + 34'd32768;
  assign rnd_mag = rnd_sum[32:16];
  assign rounded = val_q[31] ? ((rnd_mag > 17'd32768) ? -16'sd32768
                                                       : 16'(-rnd_mag))
                             : ((rnd_mag > 17'd32767) ? 16'sd32767
                                                       : 16'(rnd_mag));

  always_comb begin
    mul_cnt = apu_pkg::MUL_CNT_W'(24);
    mul_a   = '0;
    mul_b   = {b1_q, 8'd0};
    unique case (state_q)
      S_MUL_M: begin
        mul_a = apu_pkg::MUL_A_W'(dmg);
        mul_b = {b1_q, 8'd0};
      end
      S_MUL_G2: begin
        mul_cnt = apu_pkg::MUL_CNT_W'(32);
        mul_a   = apu_pkg::MUL_A_W'(ag33);
        mul_b   = ag33[31:0];
      end
      S_MUL_V: begin
        mul_a = apu_pkg::MUL_A_W'(dvg);
        mul_b = {b2_q, 8'd0};
      end
      S_MUL_L: begin
        mul_a = apu_pkg::MUL_A_W'({1'b0, mh_q});
        mul_b = {lr_q, 8'd0};
      end
      S_PASS1: begin
        mul_a = apu_pkg::MUL_A_W'({1'b0, bp1_q});
        mul_b = {b1_q, 8'd0};
      end
      S_PASS2: begin
        mul_a = apu_pkg::MUL_A_W'({1'b0, bp2_q});
        mul_b = {b2_q, 8'd0};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    div_cnt = apu_pkg::DIV_CNT_W'(56);
    div_num = {am33[31:0], 48'd0};
    div_den = apu_pkg::DIV_D_W'(d1);
    unique case (state_q)
      S_DIV_V: begin
        div_num = {v_q, 48'd0};
        div_den = apu_pkg::DIV_D_W'(d2);
      end
      S_DIV_L: begin
        div_cnt = apu_pkg::DIV_CNT_W'(80);
        div_num = mul_p[apu_pkg::DIV_N_W-1:0];
        div_den = {den_q, 6'd0};
      end
      default: begin
        div_num = {am33[31:0], 48'd0};
      end
    endcase
  end

  assign ram_we    = state_q == S_WRITE;
  assign ram_addr  = (state_q == S_IDLE) ? apu_pkg::ADDR_W'(in_i.data.slot)
                                         : apu_pkg::ADDR_W'(slot_q);
  assign ram_wdata = '{value: val_q, first_moment: m_q, second_moment: v_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= apu_pkg::LR_RESET;
      b1_q   <= apu_pkg::B1_RESET;
      b2_q   <= apu_pkg::B2_RESET;
      stab_q <= apu_pkg::STAB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apu_pkg::REG_LEARNING_RATE: lr_q   <= cfg_data_i;
        apu_pkg::REG_BETA_ONE:      b1_q   <= cfg_data_i;
        apu_pkg::REG_BETA_TWO:      b2_q   <= cfg_data_i;
        apu_pkg::REG_STABILIZER:    stab_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      sq_start_q  <= 1'b0;
      bp1_q       <= apu_pkg::ONE_Q24;
      bp2_q       <= apu_pkg::ONE_Q24;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      sq_start_q  <= 1'b0;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q  <= in_i.data.action;
            slot_q <= in_i.data.slot;
            g_q    <= in_i.data.gradient;
            sv_q   <= in_i.data.start_value;
            hold_q <= in_i.data.hold_value;
            val_q  <= '0;
            if (slot_ok) begin
              state_q <= S_READ;
            end else if (in_i.data.action == apu_pkg::ACT_PASS) begin
              mul_start_q <= 1'b1;
              state_q     <= S_PASS1;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_READ: begin
          val_q <= ram_rdata.value;
          m_q   <= ram_rdata.first_moment;
          v_q   <= ram_rdata.second_moment;
          unique case (act_q)
            apu_pkg::ACT_LOAD: begin
              val_q   <= 32'(sv_q) <<< 16;
              m_q     <= '0;
              v_q     <= '0;
              state_q <= S_WRITE;
            end
            apu_pkg::ACT_STEP: begin
              mul_start_q <= 1'b1;
              state_q     <= S_MUL_M;
            end
            apu_pkg::ACT_PASS: begin
              mul_start_q <= 1'b1;
              state_q     <= S_PASS1;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_MUL_M: begin
          if (mul_done) begin
            m_q         <= m_new;
            mul_start_q <= 1'b1;
            state_q     <= S_MUL_G2;
          end
        end
        S_MUL_G2: begin
          if (mul_done) begin
            g2_q        <= g2_sum[63:32];
            mul_start_q <= 1'b1;
            state_q     <= S_MUL_V;
          end
        end
        S_MUL_V: begin
          if (mul_done) begin
            v_q <= v_new;
            if (hold_q || d1 == '0 || d2 == '0) begin
              state_q <= S_WRITE;
            end else begin
              div_start_q <= 1'b1;
              state_q     <= S_DIV_M;
            end
          end
        end
        S_DIV_M: begin
          if (div_done) begin
            mh_q        <= div_q[55:0];
            div_start_q <= 1'b1;
            state_q     <= S_DIV_V;
          end
        end
        S_DIV_V: begin
          if (div_done) begin
            sq_start_q <= 1'b1;
            state_q    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            den_q <= den_new;
            if (den_new == '0) begin
              state_q <= S_WRITE;
            end else begin
              mul_start_q <= 1'b1;
              state_q     <= S_MUL_L;
            end
          end
        end
        S_MUL_L: begin
          if (mul_done) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV_L;
          end
        end
        S_DIV_L: begin
          if (div_done) begin
            val_q   <= nv_sat;
            state_q <= S_WRITE;
          end
        end
        S_PASS1: begin
          if (mul_done) begin
            bp1_q       <= bp_sum[48:24];
            mul_start_q <= 1'b1;
            state_q     <= S_PASS2;
          end
        end
        S_PASS2: begin
          if (mul_done) begin
            bp2_q   <= bp_sum[48:24];
            state_q <= S_DONE;
          end
        end
        S_WRITE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_q.slot_out      <= slot_q;
            out_q.rounded_value <= rounded;
            out_q.exact_value   <= val_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  apu_ram #(
    .WIDTH (apu_pkg::ROW_W),
    .DEPTH (apu_pkg::SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  apu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .count_i (mul_cnt),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  apu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .count_i (div_cnt),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  apu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .x_i     ({8'd0, div_q[55:0]}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  a_bp1_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp1_q <= apu_pkg::ONE_Q24)
    else $error("beta_one power exceeds one");

  a_bp2_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp2_q <= apu_pkg::ONE_Q24)
    else $error("beta_two power exceeds one");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> div_den != '0)
    else $error("divider started with a zero divisor");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result issued outside of completion");

endmodule

// File: design/apu_ram.sv
// ----------------------------------------------------------------------------
// apu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module apu_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: design/apu_mul.sv
// ----------------------------------------------------------------------------
// apu_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module apu_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [apu_pkg::MUL_CNT_W-1:0]        count_i,
  input  logic signed [apu_pkg::MUL_A_W-1:0]   a_i,
  input  logic [apu_pkg::MUL_B_W-1:0]          b_i,
  output logic                                 done_o,
  output logic signed [apu_pkg::MUL_P_W-1:0]   prod_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [apu_pkg::MUL_CNT_W-1:0]       cnt_q;
  logic signed [apu_pkg::MUL_A_W-1:0]  a_q;
  logic [apu_pkg::MUL_B_W-1:0]         b_q;
  logic signed [apu_pkg::MUL_P_W-1:0]  acc_q;
  logic signed [apu_pkg::MUL_P_W-1:0]  addend;

  assign addend = b_q[apu_pkg::MUL_B_W-1] ? apu_pkg::MUL_P_W'(a_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= (acc_q <<< 1) + addend;
        b_q   <= b_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == apu_pkg::MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: design/apu_div.sv
// ----------------------------------------------------------------------------
// apu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apu_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [apu_pkg::DIV_CNT_W-1:0]   count_i,
  input  logic [apu_pkg::DIV_N_W-1:0]     num_i,
  input  logic [apu_pkg::DIV_D_W-1:0]     den_i,
  output logic                            done_o,
  output logic [apu_pkg::DIV_N_W-1:0]     quot_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [apu_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [apu_pkg::DIV_N_W-1:0]     num_q;
  logic [apu_pkg::DIV_D_W-1:0]     den_q;
  logic [apu_pkg::DIV_D_W-1:0]     rem_q;
  logic [apu_pkg::DIV_N_W-1:0]     quot_q;
  logic [apu_pkg::DIV_D_W:0]       trial;
  logic [apu_pkg::DIV_D_W:0]       diff;
  logic                            fits;

  assign trial = {rem_q, num_q[apu_pkg::DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quot_q <= '0;
      end else if (busy_q) begin
        num_q  <= num_q << 1;
        rem_q  <= fits ? diff[apu_pkg::DIV_D_W-1:0] : trial[apu_pkg::DIV_D_W-1:0];
        quot_q <= {quot_q[apu_pkg::DIV_N_W-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == apu_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: design/apu_sqrt.sv
// ----------------------------------------------------------------------------
// apu_sqrt
// Square root of a Q.28 value answered in Q.32: normalizes two bits per
// cycle, then produces one root bit per cycle and rescales the result.
// ----------------------------------------------------------------------------
module apu_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [apu_pkg::SQ_X_W-1:0]    x_i,
  output logic                          done_o,
  output logic [apu_pkg::ROOT_W-1:0]    root_o
);

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_NORM,
    SQ_ROOT,
    SQ_SCALE
  } sq_state_e;

  sq_state_e                        state_q;
  logic                             done_q;
  logic [apu_pkg::SQ_X_W-1:0]       x_q;
  logic [5:0]                       shift_q;
  logic [4:0]                       cnt_q;
  logic [33:0]                      rem_q;
  logic [31:0]                      bits_q;
  logic [apu_pkg::ROOT_W-1:0]       root_q;
  logic [33:0]                      rem_try;
  logic [33:0]                      sub_val;
  logic                             take;
  logic [4:0]                       half;

  assign rem_try = {rem_q[31:0], x_q[apu_pkg::SQ_X_W-1 -: 2]};
  assign sub_val = {bits_q, 2'b01};
  assign take    = rem_try >= sub_val;
  assign half    = shift_q[5:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            shift_q <= '0;
            state_q <= SQ_NORM;
          end
        end
        SQ_NORM: begin
          if (shift_q < 6'd62 && x_q[apu_pkg::SQ_X_W-1 -: 2] == 2'b00) begin
            x_q     <= x_q << 2;
            shift_q <= shift_q + 6'd2;
          end else begin
            rem_q   <= '0;
            bits_q  <= '0;
            cnt_q   <= '0;
            state_q <= SQ_ROOT;
          end
        end
        SQ_ROOT: begin
          rem_q  <= take ? rem_try - sub_val : rem_try;
          bits_q <= {bits_q[30:0], take};
          x_q    <= x_q << 2;
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= SQ_SCALE;
          end
        end
        SQ_SCALE: begin
          if (half <= 5'd18) begin
            root_q <= apu_pkg::ROOT_W'(bits_q) << (5'd18 - half);
          end else begin
            root_q <= apu_pkg::ROOT_W'(bits_q) >> (half - 5'd18);
          end
          done_q  <= 1'b1;
          state_q <= SQ_IDLE;
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
